@@ rtl/pfcu_pkg.sv @@
// ----------------------------------------------------------------------------
// pfcu_pkg
// Shared types and codes for the pixel format convert and upscale unit.
// ----------------------------------------------------------------------------
package pfcu_pkg;

  // Source pixel formats
  typedef enum logic [1:0] {
    FMT_BGR565   = 2'd0,
    FMT_RGBA8888 = 2'd1,
    FMT_PAGE1    = 2'd2,
    FMT_NONE     = 2'd3
  } fmt_e;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_SCALE  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_STRIDE = 3'd4;
  localparam logic [2:0] REG_ORIGIN = 3'd5;
  localparam logic [2:0] REG_SHIFTS = 3'd6;

  localparam int unsigned PADDR_W = 5;

  // Register file contents
  typedef struct packed {
    logic [1:0]  source_format;
    logic [3:0]  scale_factor;
    logic [10:0] source_width;
    logic [10:0] source_height;
    logic [14:0] row_stride_words;
    logic [23:0] origin_word;
    logic [14:0] channel_shifts;
  } cfg_t;

endpackage

@@ rtl/pfcu_front.sv @@
// ----------------------------------------------------------------------------
// pfcu_front
// Accepts source pixels, converts them to display words, tracks the raster
// position and computes the base word address of each write block.
// ----------------------------------------------------------------------------
module pfcu_front #(
  parameter int unsigned CW = 10,
  parameter int unsigned WW = 11,
  parameter int unsigned SW = 4,
  parameter int unsigned AW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfcu_pkg::cfg_t       cfg_i,
  input  logic [SW-1:0]        scale_i,
  input  logic [WW-1:0]        width_i,
  input  logic [WW-1:0]        height_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          raw_pixel_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output logic [31:0]          push_pixel_o,
  output logic [AW-1:0]        push_base_o
);
  import pfcu_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e          state_q, state_d;
  logic [CW-1:0]    col_q, col_d;
  logic [CW-1:0]    row_q, row_d;
  logic [31:0]      pixel_q;
  logic             emit_q;
  logic [CW+SW-1:0] rs_q;
  logic [CW+SW-1:0] cs_q;
  logic [AW-1:0]    base_q;

  logic             accept;
  logic [7:0]       b0, b1, b2;
  logic [7:0]       ch_r, ch_g, ch_b;
  logic [4:0]       sh_r, sh_g, sh_b;
  logic [31:0]      pixel_d;
  logic             emit_d;
  logic             aligned;
  logic [CW+SW+14:0] row_off;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == F_IDLE);

  assign b0 = raw_pixel_i[7:0];
  assign b1 = raw_pixel_i[15:8];
  assign b2 = raw_pixel_i[23:16];
  assign sh_r = cfg_i.channel_shifts[14:10];
  assign sh_g = cfg_i.channel_shifts[9:5];
  assign sh_b = cfg_i.channel_shifts[4:0];
  assign aligned = (width_i[2:0] == 3'd0) && (height_i[2:0] == 3'd0);

  // Channel expansion and placement
  always_comb begin
    ch_r    = b0;
    ch_g    = b1;
    ch_b    = b2;
    pixel_d = '0;
    emit_d  = 1'b1;
    case (fmt_e'(cfg_i.source_format))
      FMT_BGR565: begin
        ch_r    = {b1[4:0], b1[4:2]};
        ch_g    = {b0[2:0], b1[7:5], b0[2:1]};
        ch_b    = {b0[7:3], b0[7:5]};
        pixel_d = (32'(ch_r) << sh_r) | (32'(ch_g) << sh_g) | (32'(ch_b) << sh_b);
      end
      FMT_RGBA8888: begin
        pixel_d = (32'(ch_r) << sh_r) | (32'(ch_g) << sh_g) | (32'(ch_b) << sh_b);
      end
      FMT_PAGE1: begin
        emit_d  = aligned;
        pixel_d = b0[row_q[2:0]] ? 32'hffff_ffff : 32'h0;
      end
      default: begin
        emit_d = 1'b0;
      end
    endcase
  end

  // Raster counters, wrapping per row and per frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ((WW+1)'(col_q) + (WW+1)'(1) >= (WW+1)'(width_i)) begin
        col_d = '0;
        if ((WW+1)'(row_q) + (WW+1)'(1) >= (WW+1)'(height_i)) begin
          row_d = '0;
        end else begin
          row_d = row_q + CW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Sequencer: accept, multiply by stride, hand to queue if the item emits
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_MUL;
      F_MUL:  state_d = emit_q ? F_PUSH : F_IDLE;
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  assign row_off = (CW+SW+15)'(rs_q) * (CW+SW+15)'(cfg_i.row_stride_words);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (accept) emit_q <= emit_d;
    end
  end

  // Payload: pixel word, scaled position, block base address
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= pixel_d;
      rs_q    <= (CW+SW)'(row_q) * (CW+SW)'(scale_i);
      cs_q    <= (CW+SW)'(col_q) * (CW+SW)'(scale_i);
    end
    if (state_q == F_MUL) begin
      base_q <= AW'(cfg_i.origin_word) + AW'(row_off) + AW'(cs_q);
    end
  end

  assign push_valid_o = (state_q == F_PUSH);
  assign push_pixel_o = pixel_q;
  assign push_base_o  = base_q;

endmodule

@@ rtl/pfcu_fifo.sv @@
// ----------------------------------------------------------------------------
// pfcu_fifo
// Two-entry queue between the front and the back; each side stalls alone.
// ----------------------------------------------------------------------------
module pfcu_fifo #(
  parameter int unsigned DW = 56
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);
  import pfcu_pkg::*;

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ rtl/pfcu_back.sv @@
// ----------------------------------------------------------------------------
// pfcu_back
// Walks the scale-by-scale write block of each queued item and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module pfcu_back #(
  parameter int unsigned SW = 4,
  parameter int unsigned AW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] scale_i,
  input  logic [14:0]   stride_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [31:0]   pop_pixel_i,
  input  logic [AW-1:0] pop_base_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [AW-1:0] write_address_o,
  output logic [31:0]   write_pixel_o,
  output logic          last_write_o
);
  import pfcu_pkg::*;

  logic          active_q;
  logic [31:0]   pixel_q;
  logic [AW-1:0] row_addr_q;
  logic [SW-1:0] dx_q, dy_q;
  logic          out_valid_q;
  logic [AW-1:0] addr_q;
  logic [31:0]   out_pixel_q;
  logic          last_q;

  logic          issue;
  logic          dx_end, dy_end;
  logic [SW-1:0] s_last;

  assign s_last      = scale_i - SW'(1);
  assign dx_end      = (dx_q == s_last);
  assign dy_end      = (dy_q == s_last);
  assign pop_ready_o = !active_q;
  assign issue       = active_q && (!out_valid_q || out_ready_i);

  // Block walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_valid_i && pop_ready_o) begin
        active_q <= 1'b1;
      end else if (issue && dx_end && dy_end) begin
        active_q <= 1'b0;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Position within the block and output payload
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      pixel_q    <= pop_pixel_i;
      row_addr_q <= pop_base_i;
      dx_q       <= '0;
      dy_q       <= '0;
    end else if (issue) begin
      if (dx_end) begin
        dx_q       <= '0;
        dy_q       <= dy_q + SW'(1);
        row_addr_q <= row_addr_q + AW'(stride_i);
      end else begin
        dx_q <= dx_q + SW'(1);
      end
    end
    if (issue) begin
      addr_q      <= row_addr_q + AW'(dx_q);
      out_pixel_q <= pixel_q;
      last_q      <= dx_end && dy_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign write_pixel_o   = out_pixel_q;
  assign last_write_o    = last_q;

endmodule

@@ rtl/pixel_format_convert_upscale_unit.sv @@
// ----------------------------------------------------------------------------
// pixel_format_convert_upscale_unit
// Converts raster source pixels to 32-bit display words and emits an
// integer-upscaled block of framebuffer writes for each one.
// ----------------------------------------------------------------------------
// Path: the first write of a pixel's block passes the front convert, the
//   stride multiply, the queue and the back issue, in that order.
// Flow: the back end walks each block at one write per cycle while the
//   output is not stalled, and takes no new item until its block is done.
//   Items that write nothing never enter the queue.
// Reset: configuration registers return to their reset values, raster
//   counters clear and the queue and output register empty.
module pixel_format_convert_upscale_unit #(
  parameter int unsigned MAX_SCALE = 8,
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfcu_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // Source pixels
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    raw_pixel_i,
  // Framebuffer writes
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ADDR_BITS-1:0]           write_address_o,
  output logic [31:0]                    write_pixel_o,
  output logic                           last_write_o
);
  import pfcu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = $clog2(MAX_SCALE + 1);
  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned DW = 32 + AW;

  cfg_t          cfg_q;
  logic          cfg_wr;
  logic [2:0]    reg_idx;
  logic [SW-1:0] scale_eff;
  logic [WW-1:0] width_eff, height_eff;

  logic          push_valid, push_ready;
  logic [31:0]   push_pixel;
  logic [AW-1:0] push_base;
  logic          pop_valid, pop_ready;
  logic [DW-1:0] pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_format    <= 2'd0;
      cfg_q.scale_factor     <= 4'd1;
      cfg_q.source_width     <= 11'd1;
      cfg_q.source_height    <= 11'd1;
      cfg_q.row_stride_words <= 15'd1;
      cfg_q.origin_word      <= 24'd0;
      cfg_q.channel_shifts   <= 15'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FORMAT: cfg_q.source_format    <= pwdata[1:0];
        REG_SCALE:  cfg_q.scale_factor     <= pwdata[3:0];
        REG_WIDTH:  cfg_q.source_width     <= pwdata[10:0];
        REG_HEIGHT: cfg_q.source_height    <= pwdata[10:0];
        REG_STRIDE: cfg_q.row_stride_words <= pwdata[14:0];
        REG_ORIGIN: cfg_q.origin_word      <= pwdata[23:0];
        REG_SHIFTS: cfg_q.channel_shifts   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_FORMAT: prdata = 32'(cfg_q.source_format);
      REG_SCALE:  prdata = 32'(cfg_q.scale_factor);
      REG_WIDTH:  prdata = 32'(cfg_q.source_width);
      REG_HEIGHT: prdata = 32'(cfg_q.source_height);
      REG_STRIDE: prdata = 32'(cfg_q.row_stride_words);
      REG_ORIGIN: prdata = 32'(cfg_q.origin_word);
      REG_SHIFTS: prdata = 32'(cfg_q.channel_shifts);
      default:    prdata = 32'd0;
    endcase
  end

  // Effective scale and frame size: zero acts as one, large values saturate
  always_comb begin
    if (cfg_q.scale_factor == 4'd0) begin
      scale_eff = SW'(1);
    end else if (32'(cfg_q.scale_factor) > 32'(MAX_SCALE)) begin
      scale_eff = SW'(MAX_SCALE);
    end else begin
      scale_eff = SW'(cfg_q.scale_factor);
    end
    if (cfg_q.source_width == 11'd0) begin
      width_eff = WW'(1);
    end else if (32'(cfg_q.source_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(cfg_q.source_width);
    end
    if (cfg_q.source_height == 11'd0) begin
      height_eff = WW'(1);
    end else if (32'(cfg_q.source_height) > 32'(MAX_WIDTH)) begin
      height_eff = WW'(MAX_WIDTH);
    end else begin
      height_eff = WW'(cfg_q.source_height);
    end
  end

  pfcu_front #(
    .CW(CW),
    .WW(WW),
    .SW(SW),
    .AW(AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .scale_i      (scale_eff),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_pixel_i  (raw_pixel_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_pixel_o (push_pixel),
    .push_base_o  (push_base)
  );

  pfcu_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_pixel, push_base}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pfcu_back #(
    .SW(SW),
    .AW(AW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .scale_i         (scale_eff),
    .stride_i        (cfg_q.row_stride_words),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_pixel_i     (pop_data[DW-1:AW]),
    .pop_base_i      (pop_data[AW-1:0]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_pixel_o   (write_pixel_o),
    .last_write_o    (last_write_o)
  );

endmodule
